[design/acm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_pkg: shared types and codes of the accumulator machine
// Word and counter widths, action and opcode codes, result status codes,
// the instruction word layout and the execute unit's result bundle.
// ----------------------------------------------------------------------------
package acm_pkg;

   localparam int WORD_W = 24;
   localparam int CNT_W  = 12;
   localparam int OP_W   = 6;
   localparam int MODE_W = 4;

   // input word actions
   localparam logic [1:0] ACT_WRITE       = 2'd0;
   localparam logic [1:0] ACT_SET_COUNTER = 2'd1;
   localparam logic [1:0] ACT_EXECUTE     = 2'd2;

   // opcodes
   localparam logic [OP_W-1:0] OP_HALT = 6'd0;
   localparam logic [OP_W-1:0] OP_NOP  = 6'd1;
   localparam logic [OP_W-1:0] OP_LD   = 6'd16;
   localparam logic [OP_W-1:0] OP_ST   = 6'd17;
   localparam logic [OP_W-1:0] OP_EM   = 6'd18;
   localparam logic [OP_W-1:0] OP_LDX  = 6'd24;
   localparam logic [OP_W-1:0] OP_STX  = 6'd25;
   localparam logic [OP_W-1:0] OP_EMX  = 6'd26;
   localparam logic [OP_W-1:0] OP_ADD  = 6'd32;
   localparam logic [OP_W-1:0] OP_SUB  = 6'd33;
   localparam logic [OP_W-1:0] OP_CLR  = 6'd34;
   localparam logic [OP_W-1:0] OP_COM  = 6'd35;
   localparam logic [OP_W-1:0] OP_AND  = 6'd36;
   localparam logic [OP_W-1:0] OP_OR   = 6'd37;
   localparam logic [OP_W-1:0] OP_XOR  = 6'd38;
   localparam logic [OP_W-1:0] OP_ADDX = 6'd40;
   localparam logic [OP_W-1:0] OP_SUBX = 6'd41;
   localparam logic [OP_W-1:0] OP_CLRX = 6'd42;
   localparam logic [OP_W-1:0] OP_J    = 6'd48;
   localparam logic [OP_W-1:0] OP_JZ   = 6'd49;
   localparam logic [OP_W-1:0] OP_JN   = 6'd50;
   localparam logic [OP_W-1:0] OP_JP   = 6'd51;

   // addressing modes
   localparam logic [MODE_W-1:0] MODE_DIRECT    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 4'd1;
   localparam logic [MODE_W-1:0] MODE_NI_FIRST  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_NI_LAST   = 4'd4;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_HALT    = 3'd1,
      ST_OPNI    = 3'd2,
      ST_MODENI  = 3'd3,
      ST_ILLMODE = 3'd4,
      ST_UNKNOWN = 3'd5
   } status_type;

   typedef struct packed {
      logic [CNT_W-1:0]  addr;
      logic [OP_W-1:0]   opcode;
      logic [MODE_W-1:0] mode;
      logic [1:0]        spare;
   } instr_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] acc;
      logic [CNT_W-1:0]  cnt;
      logic              mem_we;
   } exec_result_type;

endpackage
`default_nettype wire

[design/acm_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_exec: instruction execute unit
// Decodes one fetched instruction against the accumulator, the already
// incremented counter and the operand word read from memory, and returns
// the new accumulator, counter, status and a store request.
// ----------------------------------------------------------------------------
module acm_exec
   import acm_pkg::*;
(
   input  instr_type          ir,
   input  logic [WORD_W-1:0]  operand_word,
   input  logic [WORD_W-1:0]  acc,
   input  logic [CNT_W-1:0]   cnt,
   output exec_result_type    res
);

   logic [WORD_W-1:0] operand;
   logic              mode_ni;

   // immediate operand is the address field, zero extended
   assign operand = (ir.mode == MODE_IMMEDIATE) ? {{(WORD_W-CNT_W){1'b0}}, ir.addr}
                                                : operand_word;
   assign mode_ni = (ir.mode >= MODE_NI_FIRST) && (ir.mode <= MODE_NI_LAST);

   // decode and execute
   always_comb begin
      res.status = ST_DONE;
      res.acc    = acc;
      res.cnt    = cnt;
      res.mem_we = 1'b0;
      case (ir.opcode)
         OP_LDX, OP_STX, OP_EMX, OP_ADDX, OP_SUBX, OP_CLRX: begin
            res.status = ST_OPNI;
         end
         OP_HALT: begin
            res.status = ST_HALT;
         end
         OP_NOP: begin
         end
         OP_CLR: begin
            res.acc = '0;
         end
         OP_COM: begin
            res.acc = ~acc;
         end
         OP_LD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
            if (ir.mode == MODE_DIRECT || ir.mode == MODE_IMMEDIATE) begin
               case (ir.opcode)
                  OP_LD:   res.acc = operand;
                  OP_ADD:  res.acc = acc + operand;
                  OP_SUB:  res.acc = acc - operand;
                  OP_AND:  res.acc = acc & operand;
                  OP_OR:   res.acc = acc | operand;
                  OP_XOR:  res.acc = acc ^ operand;
                  default: res.acc = acc;
               endcase
            end else if (mode_ni) begin
               res.status = ST_MODENI;
            end else begin
               res.status = ST_ILLMODE;
            end
         end
         OP_ST, OP_EM, OP_J, OP_JZ, OP_JN, OP_JP: begin
            if (ir.mode == MODE_DIRECT) begin
               case (ir.opcode)
                  OP_ST: res.mem_we = 1'b1;
                  OP_EM: begin
                     res.mem_we = 1'b1;
                     res.acc    = operand_word;
                  end
                  OP_J:  res.cnt = ir.addr;
                  OP_JZ: begin
                     if (acc == '0) res.cnt = ir.addr;
                  end
                  OP_JN: begin
                     if (acc[WORD_W-1]) res.cnt = ir.addr;
                  end
                  OP_JP: begin
                     if (acc != '0 && !acc[WORD_W-1]) res.cnt = ir.addr;
                  end
                  default: res.cnt = cnt;
               endcase
            end else if (mode_ni) begin
               res.status = ST_MODENI;
            end else begin
               res.status = ST_ILLMODE;
            end
         end
         default: begin
            res.status = ST_UNKNOWN;
         end
      endcase
   end

endmodule
`default_nettype wire

[design/accumulator_machine_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_machine_step: 24-bit single-accumulator machine
// Each request word writes a memory word, sets the instruction counter or
// executes one instruction; each gives exactly one response word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries action, address and data; rsp_* returns status, the
//   accumulator and the instruction counter after that request word.
//   A word moves on a channel at a clock edge with valid high, stall low.
//   Memory writes, counter sets and the unused action are worked in idle:
//   the response is registered at the accepting edge if the output register
//   is free. An execute makes one access of the single-read-port memory
//   per step: instruction fetch, operand read, then execute and write back.
//   Its response is registered at the end of the last step if the output
//   register is free; a new request word is taken as soon as the machine is back in idle.
//   A stalled response is held in the output register while the next
//   request word is taken and worked; that one then waits for the register.
//   Reset (synchronous) zeroes accumulator and counter and starts a clearing
//   pass that zeroes the memory, one word a cycle; req_stall is high during
//   the pass.
// ----------------------------------------------------------------------------
module accumulator_machine_step
   import acm_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [CNT_W-1:0]         req_address,
   input  logic [WORD_W-1:0]        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_accumulator_value,
   output logic [CNT_W-1:0]         rsp_counter_value
);

   localparam int AW        = $clog2(MEM_WORDS);
   localparam int CNT_SPAN  = 1 << CNT_W;
   localparam int RED_STEPS = $clog2((CNT_SPAN + MEM_WORDS - 1) / MEM_WORDS);
   localparam int RED_W     = CNT_W + 2;
   localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_DECODE = 5'b00100,
      S_EXEC   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   // address modulo memory depth by restoring subtract steps
   function automatic logic [AW-1:0] mem_index(input logic [CNT_W-1:0] a);
      logic [RED_W-1:0] rem;
      rem = RED_W'(a);
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (rem >= (RED_W'(MEM_WORDS) << k)) rem = rem - (RED_W'(MEM_WORDS) << k);
      end
      return rem[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   status_type        status_ff, status_in;
   instr_type         ir_ff, ir_in;
   logic [AW-1:0]     op_idx_ff, op_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [WORD_W-1:0] rsp_acc_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic [WORD_W-1:0] mem_words_ff [MEM_WORDS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     wr_idx;
   logic [WORD_W-1:0] wr_data;
   logic [CNT_W-1:0]  red_src;
   logic [AW-1:0]     red_idx;

   logic              out_free;
   logic              load_rsp;
   exec_result_type   exec_res;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared address reducer: request address or counter in idle,
   // operand address of the fetched word in decode
   always_comb begin
      if (state_ff == S_IDLE) begin
         red_src = (req_action == ACT_WRITE) ? req_address : cnt_ff;
      end else begin
         red_src = mem_rdata_ff[WORD_W-1 -: CNT_W];
      end
   end
   assign red_idx = mem_index(red_src);

   acm_exec u_exec (
      .ir           (ir_ff),
      .operand_word (mem_rdata_ff),
      .acc          (acc_ff),
      .cnt          (cnt_ff),
      .res          (exec_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      ir_in        = ir_ff;
      op_idx_in    = op_idx_ff;
      mem_we       = 1'b0;
      wr_idx       = red_idx;
      wr_data      = req_data;
      load_rsp     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_DONE;
               case (req_action)
                  ACT_WRITE:       mem_we   = 1'b1;
                  ACT_SET_COUNTER: cnt_in   = req_address;
                  ACT_EXECUTE:     state_in = S_DECODE;
                  default:         state_in = S_IDLE;
               endcase
               if (req_action != ACT_EXECUTE) begin
                  if (out_free) load_rsp = 1'b1;
                  else state_in = S_DONE;
               end
            end
         end
         S_DECODE: begin
            ir_in     = instr_type'(mem_rdata_ff);
            cnt_in    = cnt_ff + 1'b1;
            op_idx_in = red_idx;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            acc_in    = exec_res.acc;
            cnt_in    = exec_res.cnt;
            status_in = exec_res.status;
            if (exec_res.mem_we) begin
               mem_we  = 1'b1;
               wr_idx  = op_idx_ff;
               wr_data = acc_ff;
            end
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      ir_ff     <= ir_in;
      op_idx_ff <= op_idx_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_in;
         rsp_acc_ff    <= acc_in;
         rsp_cnt_ff    <= cnt_in;
      end
   end

   // machine memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem_words_ff[wr_idx] <= wr_data;
      mem_rdata_ff <= mem_words_ff[red_idx];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_accumulator_value = $signed(rsp_acc_ff);
   assign rsp_counter_value     = rsp_cnt_ff;

endmodule
`default_nettype wire

[design/acm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_checker: port-level checks of the accumulator machine
// Tracks words in flight from the two handshakes and checks reset
// behavior, response hold under stall and response bookkeeping.
// ----------------------------------------------------------------------------
module acm_checker
   import acm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [2:0]               rsp_status,
   input  logic signed [WORD_W-1:0] rsp_accumulator_value,
   input  logic [CNT_W-1:0]         rsp_counter_value
);

   logic [1:0] outst_ff, outst_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // words accepted but not yet delivered
   always_comb begin
      outst_in = outst_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) outst_ff <= '0;
      else outst_ff <= outst_in;
   end

   // reset starts the clearing pass with no response pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("request side open or response pending after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_accumulator_value) && $stable(rsp_counter_value)))
      else $error("stalled response changed");

   // a response only stands for an accepted request, with a known status
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outst_ff != 2'd0 && rsp_status <= ST_UNKNOWN))
      else $error("response without request or bad status");

   // at most one word in work behind one held response
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      outst_ff != 2'd3)
      else $error("too many words in flight");

endmodule

bind accumulator_machine_step acm_checker u_acm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_accumulator_value (rsp_accumulator_value),
   .rsp_counter_value     (rsp_counter_value)
);
`default_nettype wire
